@@ hw/rtl/hipu_pkg.sv @@
`timescale 1ns / 1ps

package hipu_pkg;

    // Field widths of the command and result words.
    localparam int CMD_W      = 3;
    localparam int PSTAT_W    = 4;
    localparam int CSTAT_W    = 5;
    localparam int LEN_W      = 4;
    localparam int DATA_W     = 64;
    localparam int ACT_W      = 3;
    localparam int POLL_W     = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int ADDR_W     = 7;
    localparam int TICKS_W    = 8;
    localparam int TIME_W     = 32;

    // Reset values of the tick registers.
    localparam logic [TICKS_W-1:0] WATCHDOG_DEF = 8'd5;
    localparam logic [TICKS_W-1:0] HOLD_DEF     = 8'd5;
    localparam logic [TICKS_W-1:0] TIMEOUT_DEF  = 8'd10;

    // Bytes in one report.
    localparam int REPORT_BYTES = 8;
    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(REPORT_BYTES);

    // Default ring depth.
    localparam int RING_DEPTH_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_PORT  = 3'd1,
        CMD_HALT  = 3'd2,
        CMD_POP   = 3'd3,
        CMD_START = 3'd4
    } t_cmd;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE     = 3'd0,
        ACT_START    = 3'd1,
        ACT_DISABLE  = 3'd2,
        ACT_ASSERT   = 3'd3,
        ACT_DEASSERT = 3'd4,
        ACT_FORCE    = 3'd5
    } t_action;

    typedef enum logic [POLL_W-1:0] {
        POLL_OK        = 2'd0,
        POLL_EMPTY     = 2'd1,
        POLL_NOT_READY = 2'd2
    } t_poll;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_ADDR     = 3'd0,
        CFG_ENDPOINT_NUM    = 3'd1,
        CFG_HOST_READY      = 3'd2,
        CFG_DEVICE_ATTACHED = 3'd3,
        CFG_WATCHDOG        = 3'd4,
        CFG_RESET_HOLD      = 3'd5,
        CFG_ENABLE_TIMEOUT  = 3'd6
    } t_cfg_idx;

    // Port-reset recovery phases.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HOLD = 3'b010,
        PH_WAIT = 3'b100
    } t_phase;

    // One command word as held in the input register.
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [PSTAT_W-1:0] port_status;
        logic [CSTAT_W-1:0] channel_status;
        logic [LEN_W-1:0]   bytes_remaining;
        logic [DATA_W-1:0]  received_data;
        logic               channel_active;
        logic               frame_odd;
        logic [LEN_W-1:0]   wanted_length;
    } t_cmd_item;

    // Configuration write.
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Result word without the report bytes, which come from the ring.
    typedef struct packed {
        t_action          action;
        logic             data_pid;
        logic             odd_frame;
        logic [LEN_W-1:0] report_length;
        t_poll            poll_status;
    } t_res_ctl;

    // Requests from the controller to the ring.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [DATA_W-1:0] data;
    } t_ring_req;

    typedef struct packed {
        logic empty;
    } t_ring_stat;

    // Byte mask keeping the low len bytes of a report.
    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < REPORT_BYTES; b++) begin
            m[8*b +: 8] = (LEN_W'(b) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

@@ hw/rtl/hipu_cmd_if.sv @@
`timescale 1ns / 1ps

interface hipu_cmd_if;
    import hipu_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [PSTAT_W-1:0] port_status;
    logic [CSTAT_W-1:0] channel_status;
    logic [LEN_W-1:0]   bytes_remaining;
    logic [DATA_W-1:0]  received_data;
    logic               channel_active;
    logic               frame_odd;
    logic [LEN_W-1:0]   wanted_length;

    modport source (
        output valid, command, port_status, channel_status, bytes_remaining,
               received_data, channel_active, frame_odd, wanted_length,
        input  ready
    );

    modport sink (
        input  valid, command, port_status, channel_status, bytes_remaining,
               received_data, channel_active, frame_odd, wanted_length,
        output ready
    );
endinterface

@@ hw/rtl/hipu_res_if.sv @@
`timescale 1ns / 1ps

interface hipu_res_if;
    import hipu_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic              data_pid;
    logic              odd_frame;
    logic [DATA_W-1:0] report_data;
    logic [LEN_W-1:0]  report_length;
    logic [POLL_W-1:0] poll_status;

    modport source (
        output valid, action, data_pid, odd_frame, report_data, report_length,
               poll_status,
        input  ready
    );

    modport sink (
        input  valid, action, data_pid, odd_frame, report_data, report_length,
               poll_status,
        output ready
    );
endinterface

@@ hw/rtl/hipu_ring.sv @@
`timescale 1ns / 1ps

module hipu_ring #(
    parameter int DEPTH = hipu_pkg::RING_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hipu_pkg::t_ring_req          i_req,
    output hipu_pkg::t_ring_stat         o_stat,
    output logic [hipu_pkg::DATA_W-1:0]  o_rd_data
);
    import hipu_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [AW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_rd, n_rd;
    logic [AW-1:0]     wr_next;
    logic [AW-1:0]     rd_next;
    logic              full;

    // Index increments wrap at the depth, which need not be a power of two.
    assign wr_next = (r_wr == LAST) ? '0 : r_wr + 1'b1;
    assign rd_next = (r_rd == LAST) ? '0 : r_rd + 1'b1;

    // One slot is kept free so that equal indices mean empty.
    assign full         = (wr_next == r_rd);
    assign o_stat.empty = (r_wr == r_rd);
    assign o_rd_data    = r_rd_data;

    // A report that arrives when the ring is full is dropped.
    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_req.push && !full) begin
            n_wr = wr_next;
        end
        if (i_req.pop) begin
            n_rd = rd_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

    // Report storage, written at the write index and read at the head.
    always_ff @(posedge i_clk) begin
        if (i_req.push && !full) begin
            r_mem[r_wr] <= i_req.data;
        end
        if (i_req.pop) begin
            r_rd_data <= r_mem[r_rd];
        end
    end

    // The controller only pops a ring that holds a report.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.pop |-> !o_stat.empty)
        else $error("ring popped while empty");

    // A push into a full ring leaves the write index where it was.
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.push && full && !i_req.pop) |=> (r_wr == $past(r_wr)) && !o_stat.empty)
        else $error("push into a full ring moved the write index");

endmodule

@@ hw/rtl/hipu_ctrl.sv @@
`timescale 1ns / 1ps

module hipu_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  hipu_pkg::t_cmd_item   i_item,
    input  hipu_pkg::t_cfg_wr     i_cfg,
    input  hipu_pkg::t_ring_stat  i_ring,
    output hipu_pkg::t_ring_req   o_ring,
    output hipu_pkg::t_res_ctl    o_res
);
    import hipu_pkg::*;

    // Configuration registers.
    logic [ADDR_W-1:0]  r_dev_addr;
    logic               r_host_ready;
    logic [TICKS_W-1:0] r_wd_ticks;
    logic [TICKS_W-1:0] r_hold_ticks;
    logic [TICKS_W-1:0] r_timeout_ticks;

    // Polling state.
    logic [TIME_W-1:0] r_tick, n_tick;
    logic [TIME_W-1:0] r_last_start, n_last_start;
    logic [TIME_W-1:0] r_rst_start, n_rst_start;
    logic              r_pending, n_pending;
    logic              r_toggle, n_toggle;
    logic              r_link_up, n_link_up;
    logic              r_addr_valid, n_addr_valid;
    t_phase            r_phase, n_phase;

    logic              addr_ok;
    logic              dev_ready;
    logic [TIME_W-1:0] rst_elapsed;
    logic [TIME_W-1:0] wd_elapsed;
    logic              launch_en;
    logic              launch_force;
    t_action           launch_act;
    logic [LEN_W-1:0]  pop_len;

    assign addr_ok     = r_addr_valid && (r_dev_addr != '0);
    assign dev_ready   = r_host_ready && r_link_up && addr_ok;
    assign n_tick      = (i_step && (i_item.command == CMD_TICK)) ? r_tick + 1'b1 : r_tick;
    assign rst_elapsed = n_tick - r_rst_start;
    assign wd_elapsed  = n_tick - r_last_start;
    assign pop_len     = (i_item.wanted_length > FULL_LEN) ? FULL_LEN
                                                           : i_item.wanted_length;

    // Decode the command word and work out the result and the next state.
    always_comb begin
        n_last_start = r_last_start;
        n_rst_start  = r_rst_start;
        n_pending    = r_pending;
        n_toggle     = r_toggle;
        n_link_up    = r_link_up;
        n_addr_valid = r_addr_valid;
        n_phase      = r_phase;
        launch_en    = 1'b0;
        launch_force = 1'b0;
        launch_act   = ACT_START;
        o_ring.push  = 1'b0;
        o_ring.pop   = 1'b0;
        o_ring.data  = i_item.received_data;
        o_res.action        = ACT_NONE;
        o_res.data_pid      = 1'b0;
        o_res.odd_frame     = 1'b0;
        o_res.report_length = '0;
        o_res.poll_status   = POLL_EMPTY;

        if (i_step) begin
            case (i_item.command)
                CMD_TICK: begin
                    unique case (r_phase)
                        PH_HOLD: begin
                            if (r_rst_start == '0) begin
                                n_rst_start = n_tick;
                            end else if (rst_elapsed >= TIME_W'(r_hold_ticks)) begin
                                o_res.action = ACT_DEASSERT;
                                n_phase      = PH_WAIT;
                                n_rst_start  = n_tick;
                            end
                        end
                        PH_WAIT: begin
                            if (i_item.port_status[0]) begin
                                n_phase   = PH_IDLE;
                                launch_en = addr_ok;
                            end else if (rst_elapsed >= TIME_W'(r_timeout_ticks)) begin
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            if (dev_ready) begin
                                if (r_pending && (wd_elapsed >= TIME_W'(r_wd_ticks))) begin
                                    // Watchdog expiry restarts the transfer.
                                    n_pending    = 1'b0;
                                    launch_en    = 1'b1;
                                    launch_force = 1'b1;
                                    launch_act   = i_item.channel_active ? ACT_FORCE
                                                                         : ACT_START;
                                end else if (!r_pending) begin
                                    launch_en = 1'b1;
                                end
                            end
                        end
                    endcase
                end
                CMD_PORT: begin
                    // Enable lost while still connected starts a port reset.
                    if (i_item.port_status[2] && !i_item.port_status[0]
                        && i_item.port_status[1]) begin
                        o_res.action = ACT_ASSERT;
                        n_phase      = PH_HOLD;
                        n_rst_start  = '0;
                        n_pending    = 1'b0;
                    end
                    // Disconnect drops the link.
                    if (i_item.port_status[3] && !i_item.port_status[1]) begin
                        n_link_up    = 1'b0;
                        n_addr_valid = 1'b0;
                        n_pending    = 1'b0;
                    end
                end
                CMD_HALT: begin
                    if (addr_ok) begin
                        if (i_item.channel_status[0]
                            || (i_item.channel_status[1] && i_item.channel_status[2])) begin
                            n_toggle    = !r_toggle;
                            o_ring.push = (i_item.bytes_remaining < FULL_LEN);
                        end
                        n_pending = 1'b0;
                        launch_en = 1'b1;
                    end
                end
                CMD_POP: begin
                    if (!dev_ready) begin
                        o_res.poll_status = POLL_NOT_READY;
                    end else if (!i_ring.empty) begin
                        o_ring.pop          = 1'b1;
                        o_res.report_length = pop_len;
                        o_res.poll_status   = POLL_OK;
                    end
                end
                CMD_START: begin
                    if (!r_pending && addr_ok) begin
                        if (i_item.channel_active) begin
                            o_res.action = ACT_DISABLE;
                        end else begin
                            launch_en = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase

            // Transfer launch, skipped while the channel is still enabled unless forced.
            if (launch_en && (launch_force || !i_item.channel_active)) begin
                n_pending       = 1'b1;
                n_last_start    = n_tick;
                o_res.action    = launch_act;
                o_res.data_pid  = n_toggle;
                o_res.odd_frame = i_item.frame_odd;
            end
        end

        // Configuration writes that re-arm the link flags.
        if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_DEVICE_ADDR:     n_addr_valid = (i_cfg.data[ADDR_W-1:0] != '0);
                CFG_DEVICE_ATTACHED: n_link_up    = i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // Configuration registers; the endpoint number has no effect here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr      <= '0;
            r_host_ready    <= 1'b0;
            r_wd_ticks      <= WATCHDOG_DEF;
            r_hold_ticks    <= HOLD_DEF;
            r_timeout_ticks <= TIMEOUT_DEF;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_DEVICE_ADDR:    r_dev_addr      <= i_cfg.data[ADDR_W-1:0];
                CFG_HOST_READY:     r_host_ready    <= i_cfg.data[0];
                CFG_WATCHDOG:       r_wd_ticks      <= i_cfg.data;
                CFG_RESET_HOLD:     r_hold_ticks    <= i_cfg.data;
                CFG_ENABLE_TIMEOUT: r_timeout_ticks <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_last_start <= '0;
            r_rst_start  <= '0;
            r_pending    <= 1'b0;
            r_toggle     <= 1'b0;
            r_link_up    <= 1'b0;
            r_addr_valid <= 1'b0;
            r_phase      <= PH_IDLE;
        end else begin
            r_tick       <= n_tick;
            r_last_start <= n_last_start;
            r_rst_start  <= n_rst_start;
            r_pending    <= n_pending;
            r_toggle     <= n_toggle;
            r_link_up    <= n_link_up;
            r_addr_valid <= n_addr_valid;
            r_phase      <= n_phase;
        end
    end

    // Deasserting port reset always moves on to waiting for enable.
    a_deassert_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (o_res.action == ACT_DEASSERT)) |=> (r_phase == PH_WAIT))
        else $error("deassert without entering the enable wait");

    // Every started transfer is marked pending with a fresh timestamp.
    a_launch_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && ((o_res.action == ACT_START) || (o_res.action == ACT_FORCE)))
        |=> r_pending && (r_last_start == r_tick))
        else $error("started transfer not marked pending");

    // A report only leaves the ring for a ready device.
    a_pop_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ring.pop |-> dev_ready && (o_res.poll_status == POLL_OK))
        else $error("report popped for a device that is not ready");

endmodule

@@ hw/rtl/hid_interrupt_in_poller_unit.sv @@
`timescale 1ns / 1ps

// Polling controller for one HID interrupt-IN endpoint. Each command word
// taken on i_cmd gives exactly one result word on o_res, in order. A word
// is captured in an input register, decoded in one pass and written to a
// result register, so the unit takes one command per clock while o_res
// does not stall; a result is presented from the result register once its
// command has passed the input register. The ring's read register fills at
// the same edge as the result register. Received reports are kept in a ring
// of RING_DEPTH 64-bit words holding up to RING_DEPTH-1 reports; a report
// arriving when it is full is dropped. Registers are to be written through
// i_cfg_we/i_cfg_idx/i_cfg_data only while no command is in flight; the
// block itself does not enforce this.
module hid_interrupt_in_poller_unit #(
    parameter int RING_DEPTH = hipu_pkg::RING_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hipu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hipu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    hipu_cmd_if.sink                         i_cmd,
    hipu_res_if.source                       o_res
);
    import hipu_pkg::*;

    logic              r_in_valid;
    t_cmd_item         r_in;
    logic              r_out_valid;
    t_res_ctl          r_res;
    logic              adv;
    t_cfg_wr           cfg;
    t_res_ctl          res_ctl;
    t_ring_req         ring_req;
    t_ring_stat        ring_stat;
    logic [DATA_W-1:0] ring_data;

    // The held word moves on whenever the result register is free or drained.
    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || adv;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in.command         <= i_cmd.command;
            r_in.port_status     <= i_cmd.port_status;
            r_in.channel_status  <= i_cmd.channel_status;
            r_in.bytes_remaining <= i_cmd.bytes_remaining;
            r_in.received_data   <= i_cmd.received_data;
            r_in.channel_active  <= i_cmd.channel_active;
            r_in.frame_odd       <= i_cmd.frame_odd;
            r_in.wanted_length   <= i_cmd.wanted_length;
        end
    end

    hipu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .i_ring  (ring_stat),
        .o_ring  (ring_req),
        .o_res   (res_ctl)
    );

    hipu_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ring_req),
        .o_stat    (ring_stat),
        .o_rd_data (ring_data)
    );

    // Result register; the report bytes sit in the ring's read register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_res.ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res_ctl;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.action        = r_res.action;
    assign o_res.data_pid      = r_res.data_pid;
    assign o_res.odd_frame     = r_res.odd_frame;
    assign o_res.report_length = r_res.report_length;
    assign o_res.poll_status   = r_res.poll_status;
    // Bytes beyond the delivered length read as zero.
    assign o_res.report_data   = ring_data & byte_mask(r_res.report_length);

    // A word leaving the input register always lands in the result register.
    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("decoded word lost on its way to the result register");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import hipu_pkg::*;

    // Cycles in which no word moves on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 2000;
    // Length of the long receiver hold-off.
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RING_N = RING_DEPTH_DEF;

    typedef enum {MIX_NORMAL, MIX_FILL, MIX_TICKS} t_mix;

    typedef struct {
        t_action          action;
        logic             data_pid;
        logic             odd_frame;
        logic [63:0]      report_data;
        logic [LEN_W-1:0] report_length;
        t_poll            poll_status;
    } t_poll_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    hipu_cmd_if cmd_if();
    hipu_res_if res_if();

    hid_interrupt_in_poller_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if.sink),
        .o_res      (res_if.source)
    );

    // Stimulus and expectation stores.
    t_cmd_item    cmd_backlog_q[$];
    t_poll_result poll_expect_q[$];
    logic         cmd_was_taken;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_req;
    int           hold_done;
    int           hold_left;
    int           quiet_cycles;
    int           mismatch_count;
    int           cmds_sent;
    int           results_checked;
    int           action_count[6];
    int           reports_delivered;
    int           reports_dropped;

    // Register copies held by the predictor.
    logic [ADDR_W-1:0]  dev_addr;
    logic [3:0]         ep_num;
    logic               host_rdy;
    logic               dev_attached;
    logic [TICKS_W-1:0] wd_ticks;
    logic [TICKS_W-1:0] hold_ticks;
    logic [TICKS_W-1:0] timeout_ticks;

    // Poller state held by the predictor.
    logic [TIME_W-1:0] tick_cnt;
    logic [TIME_W-1:0] last_start;
    logic [TIME_W-1:0] rst_tick;
    logic              xfer_pending;
    t_phase            rst_phase;
    logic              toggle;
    logic              link_up;
    logic              addr_valid;
    logic [63:0]       report_ring [RING_N];
    int                wr_idx;
    int                rd_idx;

    // Clock: 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void reset_model();
        dev_addr      = '0;
        ep_num        = '0;
        host_rdy      = 1'b0;
        dev_attached  = 1'b0;
        wd_ticks      = WATCHDOG_DEF;
        hold_ticks    = HOLD_DEF;
        timeout_ticks = TIMEOUT_DEF;
        tick_cnt      = '0;
        last_start    = '0;
        rst_tick      = '0;
        xfer_pending  = 1'b0;
        rst_phase     = PH_IDLE;
        toggle        = 1'b0;
        link_up       = 1'b0;
        addr_valid    = 1'b0;
        wr_idx        = 0;
        rd_idx        = 0;
    endfunction

    function automatic void model_write_reg(input t_cfg_idx idx, input logic [7:0] val);
        case (idx)
            CFG_DEVICE_ADDR: begin
                dev_addr   = val[6:0];
                addr_valid = (val[6:0] != '0);
            end
            CFG_ENDPOINT_NUM:   ep_num = val[3:0];
            CFG_HOST_READY:     host_rdy = val[0];
            CFG_DEVICE_ATTACHED: begin
                dev_attached = val[0];
                link_up      = val[0];
            end
            CFG_WATCHDOG:       wd_ticks = val;
            CFG_RESET_HOLD:     hold_ticks = val;
            CFG_ENABLE_TIMEOUT: timeout_ticks = val;
            default: ;
        endcase
    endfunction

    function automatic logic addr_usable();
        return addr_valid && (dev_addr != '0);
    endfunction

    // A transfer is launched only when the channel is not already enabled.
    function automatic void start_xfer(inout t_poll_result r, input logic active,
                                       input logic odd, input t_action act);
        if (!active) begin
            xfer_pending = 1'b1;
            last_start   = tick_cnt;
            r.action     = act;
            r.data_pid   = toggle;
            r.odd_frame  = odd;
        end
    endfunction

    // New reports are dropped while the ring holds all it can.
    function automatic void ring_store(input logic [63:0] d);
        int nxt;
        nxt = (wr_idx + 1) % RING_N;
        if (nxt != rd_idx) begin
            report_ring[wr_idx] = d;
            wr_idx = nxt;
        end else begin
            reports_dropped++;
        end
    endfunction

    // Works out the result word for one command word and advances the state.
    function automatic void predict_poll(input t_cmd_item it, output t_poll_result r);
        logic        ready_ok;
        int          len;
        logic [63:0] rep;
        ready_ok        = host_rdy && link_up && addr_usable();
        r.action        = ACT_NONE;
        r.data_pid      = 1'b0;
        r.odd_frame     = 1'b0;
        r.report_data   = '0;
        r.report_length = '0;
        r.poll_status   = POLL_EMPTY;
        case (it.command)
            CMD_TICK: begin
                tick_cnt = tick_cnt + 1;
                if (rst_phase == PH_HOLD) begin
                    if (rst_tick == '0) begin
                        rst_tick = tick_cnt;
                    end else if (tick_cnt - rst_tick >= hold_ticks) begin
                        r.action  = ACT_DEASSERT;
                        rst_phase = PH_WAIT;
                        rst_tick  = tick_cnt;
                    end
                end else if (rst_phase == PH_WAIT) begin
                    if (it.port_status[0]) begin
                        rst_phase = PH_IDLE;
                        if (addr_usable()) begin
                            start_xfer(r, it.channel_active, it.frame_odd, ACT_START);
                        end
                    end else if (tick_cnt - rst_tick >= timeout_ticks) begin
                        rst_phase = PH_IDLE;
                    end
                end else begin
                    rst_phase = PH_IDLE;
                    if (ready_ok) begin
                        if (xfer_pending && (tick_cnt - last_start >= wd_ticks)) begin
                            xfer_pending = 1'b0;
                            start_xfer(r, 1'b0, it.frame_odd,
                                       it.channel_active ? ACT_FORCE : ACT_START);
                        end else if (!xfer_pending) begin
                            start_xfer(r, it.channel_active, it.frame_odd, ACT_START);
                        end
                    end
                end
            end
            CMD_PORT: begin
                if (it.port_status[2] && !it.port_status[0] && it.port_status[1]) begin
                    r.action     = ACT_ASSERT;
                    rst_phase    = PH_HOLD;
                    rst_tick     = '0;
                    xfer_pending = 1'b0;
                end
                if (it.port_status[3] && !it.port_status[1]) begin
                    link_up      = 1'b0;
                    addr_valid   = 1'b0;
                    xfer_pending = 1'b0;
                end
            end
            CMD_HALT: begin
                if (addr_usable()) begin
                    if (it.channel_status[0] ||
                        (it.channel_status[1] && it.channel_status[2])) begin
                        toggle = ~toggle;
                        if (it.bytes_remaining < 4'd8) begin
                            ring_store(it.received_data);
                        end
                    end
                    xfer_pending = 1'b0;
                    start_xfer(r, it.channel_active, it.frame_odd, ACT_START);
                end
            end
            CMD_POP: begin
                if (!ready_ok) begin
                    r.poll_status = POLL_NOT_READY;
                end else if (rd_idx != wr_idx) begin
                    len = (it.wanted_length < 4'd8) ? int'(it.wanted_length) : 8;
                    rep = report_ring[rd_idx];
                    if (len < 8) begin
                        rep = rep & ((64'd1 << (len * 8)) - 64'd1);
                    end
                    rd_idx          = (rd_idx + 1) % RING_N;
                    r.report_data   = rep;
                    r.report_length = LEN_W'(len);
                    r.poll_status   = POLL_OK;
                    reports_delivered++;
                end
            end
            CMD_START: begin
                if (!xfer_pending && addr_usable()) begin
                    if (it.channel_active) begin
                        r.action = ACT_DISABLE;
                    end else begin
                        start_xfer(r, 1'b0, it.frame_odd, ACT_START);
                    end
                end
            end
            default: ;
        endcase
        action_count[int'(r.action)]++;
    endfunction

    function automatic t_cmd_item mk_item(input t_cmd cmd, input logic [3:0] ps,
                                          input logic [4:0] cs, input logic [3:0] rem,
                                          input logic [63:0] d, input logic active,
                                          input logic odd, input logic [3:0] want);
        t_cmd_item it;
        it.command         = cmd;
        it.port_status     = ps;
        it.channel_status  = cs;
        it.bytes_remaining = rem;
        it.received_data   = d;
        it.channel_active  = active;
        it.frame_odd       = odd;
        it.wanted_length   = want;
        return it;
    endfunction

    // Random command word, mostly shaped as a healthy polling sequence.
    function automatic t_cmd_item rand_cmd_item(input t_mix mix);
        t_cmd_item it;
        int        pick;
        it.port_status     = 4'($urandom_range(15));
        it.channel_status  = 5'($urandom_range(31));
        it.bytes_remaining = 4'($urandom_range(8));
        it.received_data   = {$urandom(), $urandom()};
        it.channel_active  = ($urandom_range(99) < 15);
        it.frame_odd       = 1'($urandom_range(1));
        it.wanted_length   = 4'($urandom_range(8));
        pick = $urandom_range(99);
        case (mix)
            MIX_TICKS: begin
                it.command = (pick < 97) ? CMD_TICK : (pick < 99) ? CMD_HALT : CMD_POP;
            end
            MIX_FILL: begin
                it.command = (pick < 30) ? CMD_TICK : (pick < 80) ? CMD_HALT :
                             (pick < 92) ? CMD_START : (pick < 94) ? CMD_PORT : CMD_POP;
            end
            default: begin
                it.command = (pick < 35) ? CMD_TICK : (pick < 60) ? CMD_HALT :
                             (pick < 80) ? CMD_POP : (pick < 93) ? CMD_START : CMD_PORT;
            end
        endcase
        // Most halts report a completed transfer whose report fits.
        if (it.command == CMD_HALT && $urandom_range(99) < 80) begin
            it.channel_status[0] = 1'b1;
            it.bytes_remaining   = 4'($urandom_range(7));
        end
        // Most port events are an enable drop on a port that stays connected.
        if (it.command == CMD_PORT && $urandom_range(99) < 85) begin
            it.port_status[2:0] = 3'b110;
        end
        // Long tick runs keep the port disabled so the enable wait can time out.
        if (it.command == CMD_TICK && mix == MIX_TICKS) begin
            it.port_status[0] = 1'b0;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
                 what, got, want, results_checked);
        mismatch_count++;
    endtask

    // Register writes land at the next rising edge; the predictor follows at once.
    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        model_write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] addr, input logic [7:0] ep,
                              input logic [7:0] hr, input logic [7:0] att,
                              input logic [7:0] wd, input logic [7:0] hold,
                              input logic [7:0] tmo);
        write_reg(CFG_DEVICE_ADDR, addr);
        write_reg(CFG_ENDPOINT_NUM, ep);
        write_reg(CFG_HOST_READY, hr);
        write_reg(CFG_DEVICE_ATTACHED, att);
        write_reg(CFG_WATCHDOG, wd);
        write_reg(CFG_RESET_HOLD, hold);
        write_reg(CFG_ENABLE_TIMEOUT, tmo);
    endtask

    // Waits until every queued word has gone in and every result has come back.
    task automatic wait_drained();
        while (cmd_backlog_q.size() != 0 || cmd_if.valid || poll_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic queue_random(input t_mix mix, input int count);
        for (int k = 0; k < count; k++) begin
            cmd_backlog_q.push_back(rand_cmd_item(mix));
        end
    endtask

    // Command driver: presents the next queued word on the falling edge.
    always @(negedge i_clk) begin : drive_cmd
        t_cmd_item nxt;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_was_taken) begin
            if (cmd_backlog_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = cmd_backlog_q.pop_front();
                cmd_if.valid           <= 1'b1;
                cmd_if.command         <= nxt.command;
                cmd_if.port_status     <= nxt.port_status;
                cmd_if.channel_status  <= nxt.channel_status;
                cmd_if.bytes_remaining <= nxt.bytes_remaining;
                cmd_if.received_data   <= nxt.received_data;
                cmd_if.channel_active  <= nxt.channel_active;
                cmd_if.frame_odd       <= nxt.frame_odd;
                cmd_if.wanted_length   <= nxt.wanted_length;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_done != hold_req) begin
            res_if.ready <= 1'b0;
            hold_left    <= HOLD_OFF_CYCLES;
            hold_done    <= hold_done + 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: checks each result word, then predicts for each accepted command word.
    always @(posedge i_clk) begin : monitor
        t_cmd_item    seen;
        t_poll_result want;
        t_poll_result pred;
        cmd_was_taken <= cmd_if.valid && cmd_if.ready;
        if (res_if.valid && res_if.ready) begin
            if (poll_expect_q.size() == 0) begin
                report_mismatch("result with nothing expected", res_if.action, '0);
            end else begin
                want = poll_expect_q.pop_front();
                if (res_if.action !== want.action)
                    report_mismatch("action", res_if.action, want.action);
                if (res_if.data_pid !== want.data_pid)
                    report_mismatch("data_pid", res_if.data_pid, want.data_pid);
                if (res_if.odd_frame !== want.odd_frame)
                    report_mismatch("odd_frame", res_if.odd_frame, want.odd_frame);
                if (res_if.report_data !== want.report_data)
                    report_mismatch("report_data", res_if.report_data, want.report_data);
                if (res_if.report_length !== want.report_length)
                    report_mismatch("report_length", res_if.report_length,
                                    want.report_length);
                if (res_if.poll_status !== want.poll_status)
                    report_mismatch("poll_status", res_if.poll_status, want.poll_status);
                results_checked++;
            end
        end
        if (cmd_if.valid && cmd_if.ready) begin
            seen.command         = cmd_if.command;
            seen.port_status     = cmd_if.port_status;
            seen.channel_status  = cmd_if.channel_status;
            seen.bytes_remaining = cmd_if.bytes_remaining;
            seen.received_data   = cmd_if.received_data;
            seen.channel_active  = cmd_if.channel_active;
            seen.frame_odd       = cmd_if.frame_odd;
            seen.wanted_length   = cmd_if.wanted_length;
            predict_poll(seen, pred);
            poll_expect_q.push_back(pred);
            cmds_sent++;
        end
    end

    // Watchdog on cycles in which no word moves on either channel.
    always @(posedge i_clk) begin : stall_watch
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Stalled for %0d cycles with %0d results outstanding",
                     quiet_cycles, poll_expect_q.size());
            $display("hid_interrupt_in_poller_unit test failed");
            $finish;
        end
    end

    initial begin : stimulus
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = '0;
        i_cfg_data             = '0;
        cmd_if.valid           = 1'b0;
        cmd_if.command         = '0;
        cmd_if.port_status     = '0;
        cmd_if.channel_status  = '0;
        cmd_if.bytes_remaining = '0;
        cmd_if.received_data   = '0;
        cmd_if.channel_active  = 1'b0;
        cmd_if.frame_odd       = 1'b0;
        cmd_if.wanted_length   = '0;
        res_if.ready           = 1'b0;
        cmd_was_taken          = 1'b0;
        send_idle_pct          = 11;
        recv_idle_pct          = 11;
        hold_req               = 0;
        hold_done              = 0;
        hold_left              = 0;
        quiet_cycles           = 0;
        mismatch_count         = 0;
        cmds_sent              = 0;
        results_checked        = 0;
        reports_delivered      = 0;
        reports_dropped        = 0;
        foreach (action_count[a]) action_count[a] = 0;
        reset_model();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Before any register is written the device is not usable.
        cmd_backlog_q.push_back(mk_item(CMD_POP, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd8));
        cmd_backlog_q.push_back(mk_item(CMD_TICK, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_START, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_HALT, 4'h0, 5'h01, 4'd0, '1, 1'b0, 1'b0, 4'd0));
        wait_drained();

        // Directed walk through the polling, toggle, ring and port-reset paths.
        set_config(8'd1, 8'd0, 8'd1, 8'd1, 8'd2, 8'd1, 8'd2);
        cmd_backlog_q.push_back(mk_item(CMD_POP, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd8));
        cmd_backlog_q.push_back(mk_item(CMD_START, 4'h0, 5'h00, 4'd0, '0, 1'b1, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_START, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b1, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_START, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_HALT, 4'h0, 5'h01, 4'd0, '1, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_HALT, 4'h0, 5'h06, 4'd5,
                                        64'h0123_4567_89AB_CDEF, 1'b0, 1'b1, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_HALT, 4'h0, 5'h08, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_HALT, 4'h0, 5'h10, 4'd0, '0, 1'b1, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_TICK, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_TICK, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_TICK, 4'h0, 5'h00, 4'd0, '0, 1'b1, 1'b1, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_HALT, 4'h0, 5'h01, 4'd8,
                                        64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_HALT, 4'h0, 5'h1F, 4'd7,
                                        64'hA5A5_5A5A_C3C3_3C3C, 1'b0, 1'b1, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_POP, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd8));
        cmd_backlog_q.push_back(mk_item(CMD_POP, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd3));
        cmd_backlog_q.push_back(mk_item(CMD_POP, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_POP, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd8));
        cmd_backlog_q.push_back(mk_item(CMD_PORT, 4'h6, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_TICK, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_TICK, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_TICK, 4'h1, 5'h00, 4'd0, '0, 1'b0, 1'b1, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_PORT, 4'hE, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_TICK, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_TICK, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_TICK, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_TICK, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_PORT, 4'h8, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        cmd_backlog_q.push_back(mk_item(CMD_POP, 4'h0, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd8));
        wait_drained();

        // Shortest timers and widest address, with no idling on either side.
        set_config(8'd127, 8'd15, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(MIX_NORMAL, 90);
        wait_drained();

        // Longest reset hold, reached by a long run of ticks.
        set_config(8'd64, 8'd8, 8'd1, 8'd1, 8'd3, 8'd255, 8'd20);
        send_idle_pct = 11;
        recv_idle_pct = 11;
        cmd_backlog_q.push_back(mk_item(CMD_PORT, 4'h6, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        queue_random(MIX_TICKS, 290);
        wait_drained();

        // Longest enable wait and watchdog.
        set_config(8'd33, 8'd1, 8'd1, 8'd1, 8'd255, 8'd1, 8'd255);
        cmd_backlog_q.push_back(mk_item(CMD_PORT, 4'h6, 5'h00, 4'd0, '0, 1'b0, 1'b0, 4'd0));
        queue_random(MIX_TICKS, 290);
        wait_drained();

        // Few pops so the ring fills; the receiver holds off while words keep coming.
        set_config(8'd9, 8'd4, 8'd1, 8'd1, 8'd6, 8'd3, 8'd4);
        send_idle_pct = 0;
        hold_req = hold_req + 1;
        queue_random(MIX_FILL, 120);
        wait_drained();

        // Zero address: halts are ignored and pops find the device not ready.
        send_idle_pct = 11;
        set_config(8'd0, 8'd7, 8'd1, 8'd1, 8'd5, 8'd5, 8'd10);
        queue_random(MIX_NORMAL, 20);
        wait_drained();

        // Host not ready and no device attached.
        set_config(8'd77, 8'd2, 8'd0, 8'd0, 8'd5, 8'd5, 8'd10);
        queue_random(MIX_NORMAL, 20);
        wait_drained();

        // Back to a working device to drain the ring.
        set_config(8'd100, 8'd11, 8'd1, 8'd1, 8'd4, 8'd2, 8'd3);
        queue_random(MIX_NORMAL, 50);
        wait_drained();

        if (poll_expect_q.size() != 0) begin
            report_mismatch("results never delivered", poll_expect_q.size(), '0);
        end
        $display("Run covered %0d commands and %0d results: %0d starts, %0d forced restarts,",
                 cmds_sent, results_checked, action_count[int'(ACT_START)],
                 action_count[int'(ACT_FORCE)]);
        $display("%0d disables, %0d/%0d port resets, %0d reports popped, %0d dropped when full.",
                 action_count[int'(ACT_DISABLE)], action_count[int'(ACT_ASSERT)],
                 action_count[int'(ACT_DEASSERT)], reports_delivered, reports_dropped);
        if (mismatch_count == 0) begin
            $display("hid_interrupt_in_poller_unit test passed");
        end else begin
            $display("hid_interrupt_in_poller_unit test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/hipu_pkg.sv
hw/rtl/hipu_cmd_if.sv
hw/rtl/hipu_res_if.sv
hw/rtl/hipu_ring.sv
hw/rtl/hipu_ctrl.sv
hw/rtl/hid_interrupt_in_poller_unit.sv
tb/tb_top.sv
